[design/shr_pkg.sv]
// Shared types, constants and pointer helpers for the string history ring.
`default_nettype none
package shr_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int OPC_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 16;
   localparam int POS_W      = 10;

   // Longest record the ring takes, terminator included.
   localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W+1)'(RING_DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic [OPC_W-1:0] {
      OP_CLEAR = 3'd0,
      OP_BEGIN = 3'd1,
      OP_PUT   = 3'd2,
      OP_FIND  = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  record_length;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [BYTE_W-1:0] read_byte;
      logic              is_terminator;
      logic [POS_W-1:0]  next_position;
      logic [POS_W-1:0]  record_start;
      logic [POS_W-1:0]  front_pos;
      logic [POS_W-1:0]  rear_pos;
      logic              is_empty;
      logic [POS_W-1:0]  free_room;
   } rsp_type;

   function automatic ptr_type ptr_inc(input ptr_type p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - 1'b1;
   endfunction

   // Free bytes, one slot always kept empty.
   function automatic ptr_type room_of(input ptr_type front, input ptr_type rear);
      ptr_type r;
      if (front >= rear) begin
         r = PTR_W'(RING_DEPTH - 1) - (front - rear);
      end else begin
         r = rear - front - 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[design/shr_if.sv]
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface shr_req_if;
   logic                          valid;
   logic                          ready;
   logic [shr_pkg::OPC_W-1:0]     opcode;
   logic [shr_pkg::BYTE_W-1:0]    data_byte;
   logic [shr_pkg::LEN_W-1:0]     record_length;
   logic [shr_pkg::POS_W-1:0]     position;

   modport source(output valid, opcode, data_byte, record_length, position, input ready);
   modport sink(input valid, opcode, data_byte, record_length, position, output ready);
endinterface

interface shr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [shr_pkg::BYTE_W-1:0]    read_byte;
   logic                          is_terminator;
   logic [shr_pkg::POS_W-1:0]     next_position;
   logic [shr_pkg::POS_W-1:0]     record_start;
   logic [shr_pkg::POS_W-1:0]     front_pos;
   logic [shr_pkg::POS_W-1:0]     rear_pos;
   logic                          is_empty;
   logic [shr_pkg::POS_W-1:0]     free_room;

   modport source(output valid, accepted, read_byte, is_terminator, next_position,
                  record_start, front_pos, rear_pos, is_empty, free_room, input ready);
   modport sink(input valid, accepted, read_byte, is_terminator, next_position,
                record_start, front_pos, rear_pos, is_empty, free_room, output ready);
endinterface
`default_nettype wire

[design/shr_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module shr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[design/shr_engine.sv]
// Sequencer, pointers and ring store port for the string history ring.
`default_nettype none
module shr_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire shr_pkg::req_type req,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output shr_pkg::rsp_type      res
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EV_CHECK,
      ST_EV_SCAN,
      ST_EV_DATA,
      ST_FIND_CHECK,
      ST_FIND_DATA,
      ST_READ_DATA,
      ST_DONE
   } state_type;

   state_type                     state_ff, state_in;
   shr_pkg::ptr_type              front_ff, front_in;
   shr_pkg::ptr_type              rear_ff, rear_in;
   logic                          rejected_ff, rejected_in;
   shr_pkg::ptr_type              clr_ff, clr_in;
   logic [shr_pkg::OPC_W-1:0]     op_ff, op_in;
   logic [shr_pkg::LEN_W-1:0]     len_ff, len_in;
   shr_pkg::ptr_type              idx_ff, idx_in;
   logic                          accepted_ff, accepted_in;
   logic [shr_pkg::BYTE_W-1:0]    rbyte_ff, rbyte_in;
   shr_pkg::ptr_type              nextp_ff, nextp_in;
   shr_pkg::ptr_type              start_ff, start_in;

   logic                          mem_we;
   shr_pkg::ptr_type              mem_addr;
   logic [shr_pkg::BYTE_W-1:0]    mem_wdata;
   logic [shr_pkg::BYTE_W-1:0]    mem_rdata;
   shr_pkg::ptr_type              room;
   logic                          req_fire;

   shr_ram #(
      .WIDTH(shr_pkg::BYTE_W),
      .DEPTH(shr_pkg::RING_DEPTH)
   ) u_ring (
      .clock(clock),
      .we   (mem_we),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   assign room      = shr_pkg::room_of(front_ff, rear_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      rear_in     = rear_ff;
      rejected_in = rejected_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      accepted_in = accepted_ff;
      rbyte_in    = rbyte_ff;
      nextp_in    = nextp_ff;
      start_in    = start_ff;
      mem_we      = 1'b0;
      mem_addr    = rear_ff;
      mem_wdata   = '0;

      case (state_ff)
         ST_CLEAR: begin
            // zero the store once after reset
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = shr_pkg::ptr_inc(clr_ff);
            if (clr_ff == shr_pkg::PTR_W'(shr_pkg::RING_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req.opcode;
               len_in      = req.record_length;
               idx_in      = req.position;
               accepted_in = 1'b1;
               rbyte_in    = '0;
               nextp_in    = '0;
               start_in    = '0;
               state_in    = ST_DONE;
               case (req.opcode)
                  shr_pkg::OP_CLEAR: begin
                     front_in    = '0;
                     rear_in     = '0;
                     rejected_in = 1'b0;
                  end
                  shr_pkg::OP_BEGIN: begin
                     if ({1'b0, req.record_length} > shr_pkg::LEN_LIMIT) begin
                        rejected_in = 1'b1;
                        accepted_in = 1'b0;
                     end else begin
                        rejected_in = 1'b0;
                        state_in    = ST_EV_CHECK;
                     end
                  end
                  shr_pkg::OP_PUT: begin
                     if (rejected_ff) begin
                        accepted_in = 1'b0;
                     end else begin
                        front_in  = shr_pkg::ptr_inc(front_ff);
                        mem_we    = 1'b1;
                        mem_addr  = shr_pkg::ptr_inc(front_ff);
                        mem_wdata = req.data_byte;
                     end
                  end
                  shr_pkg::OP_FIND: begin
                     state_in = ST_FIND_CHECK;
                  end
                  shr_pkg::OP_READ: begin
                     mem_addr = req.position;
                     state_in = ST_READ_DATA;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EV_CHECK: begin
            if (shr_pkg::LEN_W'(room) > len_ff) begin
               if (rear_ff == front_ff) begin
                  rear_in = shr_pkg::ptr_inc(rear_ff);
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_EV_SCAN;
            end
         end
         ST_EV_SCAN: begin
            if (rear_ff == front_ff) begin
               // ring ran empty: step past the front slot
               rear_in  = shr_pkg::ptr_inc(rear_ff);
               state_in = ST_DONE;
            end else begin
               mem_addr = rear_ff;
               state_in = ST_EV_DATA;
            end
         end
         ST_EV_DATA: begin
            rear_in = shr_pkg::ptr_inc(rear_ff);
            if (mem_rdata == '0) begin
               state_in = ST_EV_CHECK;
            end else begin
               state_in = ST_EV_SCAN;
            end
         end
         ST_FIND_CHECK: begin
            if (idx_ff == rear_ff) begin
               start_in = idx_ff;
               state_in = ST_DONE;
            end else begin
               mem_addr = shr_pkg::ptr_dec(idx_ff);
               state_in = ST_FIND_DATA;
            end
         end
         ST_FIND_DATA: begin
            if (mem_rdata == '0) begin
               start_in = idx_ff;
               state_in = ST_DONE;
            end else begin
               idx_in   = shr_pkg::ptr_dec(idx_ff);
               state_in = ST_FIND_CHECK;
            end
         end
         ST_READ_DATA: begin
            rbyte_in = mem_rdata;
            nextp_in = shr_pkg::ptr_inc(idx_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         front_ff    <= '0;
         rear_ff     <= '0;
         rejected_ff <= 1'b0;
         clr_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         front_ff    <= front_in;
         rear_ff     <= rear_in;
         rejected_ff <= rejected_in;
         clr_ff      <= clr_in;
      end
      op_ff       <= op_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      accepted_ff <= accepted_in;
      rbyte_ff    <= rbyte_in;
      nextp_ff    <= nextp_in;
      start_ff    <= start_in;
   end

   always_comb begin
      res.accepted      = accepted_ff;
      res.read_byte     = rbyte_ff;
      res.is_terminator = (op_ff == shr_pkg::OP_READ) && (rbyte_ff == '0);
      res.next_position = nextp_ff;
      res.record_start  = start_ff;
      res.front_pos     = front_ff;
      res.rear_pos      = rear_ff;
      res.is_empty      = (front_ff == rear_ff);
      res.free_room     = room;
   end

   // front moves only on an accepted put or clear
   a_front_moves_on_accept: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(front_ff))
      else $error("front pointer moved without an accepted word");

   // a begin that fits never leaves the ring looking empty
   a_begin_not_empty: assert property (@(posedge clock) disable iff (reset)
      ($rose(state_ff == ST_DONE) && op_ff == shr_pkg::OP_BEGIN && accepted_ff)
      |-> (front_ff != rear_ff))
      else $error("begin left front equal to rear");

   // eviction only runs for a begin that was not rejected
   a_evict_not_rejected: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV_SCAN || state_ff == ST_EV_DATA || state_ff == ST_EV_CHECK)
      |-> !rejected_ff)
      else $error("eviction running with record rejected");

endmodule
`default_nettype wire

[design/string_history_ring.sv]
// Top level of the string history ring: engine plus response output register.
//
// channel   dir  handshake          word
// req_ch    in   valid/ready        opcode, data_byte, record_length, position
// rsp_ch    out  valid/ready        accepted, read_byte, is_terminator, next_position,
//                                   record_start, front_pos, rear_pos, is_empty, free_room
//
// Find start walks back one byte at a time until a terminator or the rear; begin
// checks room and evicts the oldest bytes until the record fits, stepping past the
// front slot when the ring runs empty. All walks go through the single ring RAM port.
// Reset: synchronous; a pass over every ring address then zeros the ring, req_ch.ready low.
// Stalls: a finished word waits in the output register; the engine holds its
// result while that register is full and not being taken.
`default_nettype none
module string_history_ring (
   input  wire logic clock,
   input  wire logic reset,
   shr_req_if.sink   req_ch,
   shr_rsp_if.source rsp_ch
);

   shr_pkg::req_type req;
   shr_pkg::rsp_type res;
   logic             res_valid;
   logic             res_ready;
   logic             req_ready;

   logic             rsp_valid_ff, rsp_valid_in;
   shr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign req.opcode        = req_ch.opcode;
   assign req.data_byte     = req_ch.data_byte;
   assign req.record_length = req_ch.record_length;
   assign req.position      = req_ch.position;
   assign req_ch.ready      = req_ready;

   shr_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ready),
      .req      (req),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res      (res)
   );

   // load the output word when the slot is free or is being drained
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accepted      = rsp_data_ff.accepted;
   assign rsp_ch.read_byte     = rsp_data_ff.read_byte;
   assign rsp_ch.is_terminator = rsp_data_ff.is_terminator;
   assign rsp_ch.next_position = rsp_data_ff.next_position;
   assign rsp_ch.record_start  = rsp_data_ff.record_start;
   assign rsp_ch.front_pos     = rsp_data_ff.front_pos;
   assign rsp_ch.rear_pos      = rsp_data_ff.rear_pos;
   assign rsp_ch.is_empty      = rsp_data_ff.is_empty;
   assign rsp_ch.free_room     = rsp_data_ff.free_room;

endmodule
`default_nettype wire

[tb/string_history_ring_tb.sv]
// Self-checking testbench for string_history_ring: random traffic against a ring predictor.
`timescale 1ns / 1ps
module string_history_ring_tb;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 900;
   localparam int LAST_POS     = shr_pkg::RING_DEPTH - 1;
   // The limit leaves room for long scans, long stalls on both sides and the
   // clearing pass after reset; they fit easily.
   localparam int CYCLE_LIMIT  = 3_000_000;
   // Quiet time after the last response, longer than any single scan.
   localparam int DRAIN_CYCLES = 2_200;

   // Opcodes the block decodes as no-ops.
   localparam logic [shr_pkg::OPC_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [shr_pkg::OPC_W-1:0] OP_UNUSED_LAST  = 3'd7;

   logic clock;
   logic reset;

   shr_req_if req_if ();
   shr_rsp_if rsp_if ();

   string_history_ring u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: a private copy of the ring and its pointers.
   // ---------------------------------------------------------------------------
   logic [shr_pkg::BYTE_W-1:0] ring_copy [shr_pkg::RING_DEPTH];
   shr_pkg::ptr_type           model_front;
   shr_pkg::ptr_type           model_rear;
   bit                         model_dropping;   // set by an oversize begin, puts are dropped

   shr_pkg::req_type req_words_q [$];     // words waiting to be driven
   shr_pkg::rsp_type status_due_q [$];    // responses predicted for accepted words

   int unsigned error_count;
   int unsigned cycle_count;

   // Generator-side view of the front pointer, only used to aim positions.
   int gen_front;
   bit gen_dropping;
   int counted_items;

   bit quiet_mode;

   function automatic shr_pkg::ptr_type step_fwd(input shr_pkg::ptr_type p);
      return shr_pkg::ptr_type'((int'(p) + 1) % shr_pkg::RING_DEPTH);
   endfunction

   function automatic shr_pkg::ptr_type step_back(input shr_pkg::ptr_type p);
      return shr_pkg::ptr_type'((int'(p) + shr_pkg::RING_DEPTH - 1) % shr_pkg::RING_DEPTH);
   endfunction

   // Free bytes with one slot reserved.
   function automatic int free_bytes();
      if (model_front >= model_rear) begin
         return shr_pkg::RING_DEPTH - 1 - (int'(model_front) - int'(model_rear));
      end
      return int'(model_rear) - int'(model_front) - 1;
   endfunction

   // Apply one request word to the ring copy and return the response it gives.
   function automatic shr_pkg::rsp_type predict_ring_word(input shr_pkg::req_type w);
      shr_pkg::rsp_type r;
      int               len;
      int               walked;
      int               room;
      shr_pkg::ptr_type p;
      r          = '0;
      r.accepted = 1'b1;
      case (w.opcode)
         shr_pkg::OP_CLEAR: begin
            // pointers only, stored bytes stay
            model_front    = '0;
            model_rear     = '0;
            model_dropping = 1'b0;
         end
         shr_pkg::OP_BEGIN: begin
            len = int'(w.record_length);
            if (len > shr_pkg::RING_DEPTH) begin
               model_dropping = 1'b1;
               r.accepted     = 1'b0;
            end else begin
               model_dropping = 1'b0;
               // evict whole oldest records; the scan also stops at the front
               while (free_bytes() <= len) begin
                  while (ring_copy[model_rear] != '0 && model_rear != model_front) begin
                     model_rear = step_fwd(model_rear);
                  end
                  if (model_rear == model_front) break;
                  model_rear = step_fwd(model_rear);
               end
               if (model_rear == model_front) model_rear = step_fwd(model_rear);
            end
         end
         shr_pkg::OP_PUT: begin
            if (model_dropping) begin
               r.accepted = 1'b0;
            end else begin
               // no length check: extra puts may run over the oldest bytes
               model_front            = step_fwd(model_front);
               ring_copy[model_front] = w.data_byte;
            end
         end
         shr_pkg::OP_FIND: begin
            // walk back to the byte after the previous terminator, or stop at rear
            p      = shr_pkg::ptr_type'(w.position);
            walked = 0;
            while (p != model_rear && walked < shr_pkg::RING_DEPTH) begin
               p = step_back(p);
               walked++;
               if (ring_copy[p] == '0) begin
                  p = step_fwd(p);
                  break;
               end
            end
            r.record_start = p;
         end
         shr_pkg::OP_READ: begin
            r.read_byte     = ring_copy[shr_pkg::ptr_type'(w.position)];
            r.is_terminator = (r.read_byte == '0);
            r.next_position = step_fwd(shr_pkg::ptr_type'(w.position));
         end
         default: begin
         end
      endcase
      room        = free_bytes();
      r.front_pos = model_front;
      r.rear_pos  = model_rear;
      r.is_empty  = (model_front == model_rear);
      r.free_room = (room > LAST_POS) ? shr_pkg::POS_W'(LAST_POS) : shr_pkg::POS_W'(room);
      return r;
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned idle_len();
      int unsigned r;
      if ($urandom_range(0, 39) == 0) quiet_mode = !quiet_mode;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Queue one request word and track where the front will end up.
   task automatic queue_word(input logic [shr_pkg::OPC_W-1:0] op, input int data,
                             input int len, input int pos);
      shr_pkg::req_type w;
      w.opcode        = op;
      w.data_byte     = shr_pkg::BYTE_W'(data);
      w.record_length = shr_pkg::LEN_W'(len);
      w.position      = shr_pkg::POS_W'(pos);
      req_words_q.push_back(w);
      if (op < OP_UNUSED_FIRST && !(op == shr_pkg::OP_PUT && gen_dropping)) counted_items++;
      case (op)
         shr_pkg::OP_CLEAR: begin
            gen_front    = 0;
            gen_dropping = 1'b0;
         end
         shr_pkg::OP_BEGIN: gen_dropping = (len > shr_pkg::RING_DEPTH);
         shr_pkg::OP_PUT: if (!gen_dropping) gen_front = (gen_front + 1) % shr_pkg::RING_DEPTH;
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Request driver: one word at a time from req_words_q, random gaps between.
   // ---------------------------------------------------------------------------
   shr_pkg::req_type cur_word;
   bit               send_pending;
   int unsigned      gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_pending = 1'b0;
         gap_left     = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            status_due_q.push_back(predict_ring_word(cur_word));
            send_pending = 1'b0;
         end
         if (!send_pending) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (req_words_q.size() > 0) begin
               cur_word = req_words_q.pop_front();
               req_if.valid         <= 1'b1;
               req_if.opcode        <= cur_word.opcode;
               req_if.data_byte     <= cur_word.data_byte;
               req_if.record_length <= cur_word.record_length;
               req_if.position      <= cur_word.position;
               send_pending = 1'b1;
               gap_left     = idle_len();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: random back-pressure, each word checked against the
   // oldest prediction.
   // ---------------------------------------------------------------------------
   shr_pkg::rsp_type due;
   int unsigned      stall_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (status_due_q.size() == 0) begin
               $error("response word with no request outstanding");
               error_count++;
            end else begin
               due = status_due_q.pop_front();
               check_field("accepted", due.accepted, rsp_if.accepted);
               check_field("read_byte", due.read_byte, rsp_if.read_byte);
               check_field("is_terminator", due.is_terminator, rsp_if.is_terminator);
               check_field("next_position", due.next_position, rsp_if.next_position);
               check_field("record_start", due.record_start, rsp_if.record_start);
               check_field("front_pos", due.front_pos, rsp_if.front_pos);
               check_field("rear_pos", due.rear_pos, rsp_if.rear_pos);
               check_field("is_empty", due.is_empty, rsp_if.is_empty);
               check_field("free_room", due.free_room, rsp_if.free_room);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = idle_len();
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("string_history_ring test failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------------
   initial begin
      int i;
      int k;
      int len;
      int n;
      int extra;
      int pick;
      int start;

      // known inputs from time zero
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.opcode        = shr_pkg::OP_CLEAR;
      req_if.data_byte     = '0;
      req_if.record_length = '0;
      req_if.position      = '0;
      rsp_if.ready         = 1'b0;

      for (i = 0; i < shr_pkg::RING_DEPTH; i++) ring_copy[i] = '0;
      model_front    = '0;
      model_rear     = '0;
      model_dropping = 1'b0;
      error_count    = 0;
      quiet_mode     = 1'b0;
      gen_front      = 0;
      gen_dropping   = 1'b0;
      counted_items  = 0;

      // --- directed words ---
      // fresh ring: read and find at both ends of the position range
      queue_word(shr_pkg::OP_READ, 0, 1, 0);
      queue_word(shr_pkg::OP_READ, 0, 1, LAST_POS);          // next position wraps to 0
      queue_word(shr_pkg::OP_FIND, 0, 1, 0);                 // starts at rear, returns it
      queue_word(shr_pkg::OP_FIND, 0, 1, LAST_POS);
      // shortest record: terminator only
      queue_word(shr_pkg::OP_BEGIN, 0, 1, 0);
      queue_word(shr_pkg::OP_PUT, 0, 1, 0);
      // data byte extremes
      queue_word(shr_pkg::OP_BEGIN, 0, 4, 0);
      queue_word(shr_pkg::OP_PUT, 8'hFF, 1, 0);
      queue_word(shr_pkg::OP_PUT, 8'h01, 1, 0);
      queue_word(shr_pkg::OP_PUT, 8'h80, 1, 0);
      queue_word(shr_pkg::OP_PUT, 0, 1, 0);
      queue_word(shr_pkg::OP_FIND, 0, 1, gen_front - 1);     // middle of the record
      queue_word(shr_pkg::OP_READ, 0, 1, gen_front - 3);
      // oversize begins; the puts after them are dropped
      queue_word(shr_pkg::OP_BEGIN, 0, 16'hFFFF, 0);
      queue_word(shr_pkg::OP_PUT, 8'h55, 1, 0);
      queue_word(shr_pkg::OP_BEGIN, 0, shr_pkg::RING_DEPTH + 1, 0);
      // longest record that fits: evicts everything
      queue_word(shr_pkg::OP_BEGIN, 0, shr_pkg::RING_DEPTH, 0);
      queue_word(shr_pkg::OP_PUT, 8'h7E, 1, 0);
      queue_word(shr_pkg::OP_PUT, 0, 1, 0);
      // more puts than declared
      queue_word(shr_pkg::OP_BEGIN, 0, 2, 0);
      queue_word(shr_pkg::OP_PUT, 8'h2A, 1, 0);
      queue_word(shr_pkg::OP_PUT, 0, 1, 0);
      queue_word(shr_pkg::OP_PUT, 8'h3C, 1, 0);
      queue_word(shr_pkg::OP_PUT, 0, 1, 0);
      for (k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) queue_word(k, 8'hA5, 16'h5A5A, 341);
      // clear keeps the store; put with no begin after it
      queue_word(shr_pkg::OP_CLEAR, 0, 1, 0);
      queue_word(shr_pkg::OP_PUT, 8'h11, 1, 0);

      // --- random words ---
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            // well-formed record, occasionally one with the wrong byte count
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 500)
                                              : $urandom_range(1, 24);
            queue_word(shr_pkg::OP_BEGIN, 0, len, $urandom());
            extra = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
            n     = (len + extra < 1) ? 1 : len + extra;
            for (k = 1; k < n; k++) begin
               queue_word(shr_pkg::OP_PUT, $urandom_range(1, 255), 1, $urandom());
            end
            queue_word(shr_pkg::OP_PUT, 0, 1, $urandom());
            if ($urandom_range(0, 2) == 0) begin
               queue_word(shr_pkg::OP_FIND, 0, 1, gen_front - int'($urandom_range(0, len)));
            end
         end else if (pick < 60) begin
            // big begin that may force eviction, then a short record body
            len = $urandom_range(300, shr_pkg::RING_DEPTH);
            queue_word(shr_pkg::OP_BEGIN, 0, len, $urandom());
            n = $urandom_range(0, 4);
            for (k = 0; k < n; k++) begin
               queue_word(shr_pkg::OP_PUT, $urandom_range(1, 255), 1, $urandom());
            end
            queue_word(shr_pkg::OP_PUT, 0, 1, $urandom());
         end else if (pick < 65) begin
            // oversize begin with puts that must be dropped
            queue_word(shr_pkg::OP_BEGIN, 0,
                       $urandom_range(shr_pkg::RING_DEPTH + 1, 16'hFFFF), $urandom());
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) queue_word(shr_pkg::OP_PUT, $urandom(), 1, $urandom());
         end else if (pick < 80) begin
            // finds and reads, near the front or anywhere
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
               start = ($urandom_range(0, 1) == 0) ? gen_front - int'($urandom_range(0, 40))
                                                   : int'($urandom_range(0, LAST_POS));
               queue_word(($urandom_range(0, 1) == 0) ? shr_pkg::OP_FIND : shr_pkg::OP_READ,
                          $urandom(), $urandom_range(1, 16'hFFFF), start);
            end
         end else if (pick < 85) begin
            // byte-by-byte copy of the newest bytes
            n     = $urandom_range(0, 20);
            start = gen_front - n;
            for (k = 0; k <= n; k++) queue_word(shr_pkg::OP_READ, 0, 1, start + k);
         end else if (pick < 87) begin
            queue_word(shr_pkg::OP_CLEAR, $urandom(), $urandom_range(1, 16'hFFFF), $urandom());
         end else begin
            // noise: any opcode, any fields
            queue_word($urandom_range(shr_pkg::OP_CLEAR, OP_UNUSED_LAST), $urandom(),
                       $urandom_range(1, 16'hFFFF), $urandom());
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // all words sent and every predicted response back
      while (req_words_q.size() != 0 || send_pending || status_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && status_due_q.size() == 0) begin
         $display("string_history_ring test passed");
      end else begin
         $display("string_history_ring test failed");
      end
      $finish;
   end

endmodule
